FILE: src/pipr_pkg.sv
// ----------------------------------------------------------------------------
// pipr_pkg
// shared constants, codes and types of the point in polygon ring unit
// ----------------------------------------------------------------------------
package pipr_pkg;

    // defaults of the top level parameters
    localparam int MAX_VERTS_DEF  = 1024;
    localparam int NUM_RINGS_DEF  = 5;
    localparam int COORD_BITS_DEF = 32;

    // fixed field and register widths
    localparam int NUM_COUNT_REGS = 5;
    localparam int CNT_W          = 11;
    localparam int CROSS_W        = 13;
    localparam int COORD_W        = 32;
    localparam int RING_SEL_W     = 3;
    localparam int VIDX_W         = 10;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;

    // item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_WALK,
        WS_DRAIN,
        WS_RESULT
    } walk_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } walk_stat_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } edge_stat_t;

endpackage

FILE: src/pipr_in_if.sv
// ----------------------------------------------------------------------------
// pipr_in_if
// input item channel: vertex loads and point queries
// ----------------------------------------------------------------------------
interface pipr_in_if;

    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic [pipr_pkg::RING_SEL_W-1:0]        ring_sel;
    logic [pipr_pkg::VIDX_W-1:0]            vertex_index;
    logic signed [pipr_pkg::COORD_W-1:0]    coord_east;
    logic signed [pipr_pkg::COORD_W-1:0]    coord_north;

    modport source
    (
        output valid, op, ring_sel, vertex_index, coord_east, coord_north,
        input  ready
    );

    modport sink
    (
        input  valid, op, ring_sel, vertex_index, coord_east, coord_north,
        output ready
    );

endinterface

FILE: src/pipr_out_if.sv
// ----------------------------------------------------------------------------
// pipr_out_if
// result item channel: crossing count and inside flag
// ----------------------------------------------------------------------------
interface pipr_out_if;

    logic                               valid;
    logic                               ready;
    logic                               inside_res;
    logic [pipr_pkg::CROSS_W-1:0]       crossings;

    modport source
    (
        output valid, inside_res, crossings,
        input  ready
    );

    modport sink
    (
        input  valid, inside_res, crossings,
        output ready
    );

endinterface

FILE: src/pipr_ram.sv
// ----------------------------------------------------------------------------
// pipr_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module pipr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 5120
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pipr_edge_unit.sv
// ----------------------------------------------------------------------------
// pipr_edge_unit
// three stage edge test: straddle check and exact cross-multiplied compare
// ----------------------------------------------------------------------------
module pipr_edge_unit #(
    parameter int COORD_BITS = pipr_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         edge_valid,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    input  logic signed [COORD_BITS-1:0] nx,
    input  logic signed [COORD_BITS-1:0] ny,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output pipr_pkg::edge_stat_t         stat
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 hit_reg;
    logic                 hit_next;

    logic signed [DW-1:0] s1_a_reg;
    logic signed [DW-1:0] s1_b_reg;
    logic signed [DW-1:0] s1_c_reg;
    logic signed [DW-1:0] s1_d_reg;
    logic                 s1_strad_reg;
    logic signed [PW-1:0] s2_l_reg;
    logic signed [PW-1:0] s2_r_reg;
    logic                 s2_strad_reg;
    logic                 s2_dneg_reg;

    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] y_ext;
    logic signed [DW-1:0] nx_ext;
    logic signed [DW-1:0] ny_ext;
    logic signed [DW-1:0] px_ext;
    logic signed [DW-1:0] py_ext;

    assign x_ext  = {x[COORD_BITS-1], x};
    assign y_ext  = {y[COORD_BITS-1], y};
    assign nx_ext = {nx[COORD_BITS-1], nx};
    assign ny_ext = {ny[COORD_BITS-1], ny};
    assign px_ext = {px[COORD_BITS-1], px};
    assign py_ext = {py[COORD_BITS-1], py};

    // sign of d flips the sense of the compare
    always_comb
    begin
        if (s2_dneg_reg)
        begin
            hit_next = s2_valid_reg && s2_strad_reg && (s2_r_reg < s2_l_reg);
        end
        else
        begin
            hit_next = s2_valid_reg && s2_strad_reg && (s2_l_reg < s2_r_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= edge_valid;
            s2_valid_reg <= s1_valid_reg;
            hit_reg      <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg     <= py_ext - ny_ext;
        s1_b_reg     <= x_ext - nx_ext;
        s1_c_reg     <= px_ext - nx_ext;
        s1_d_reg     <= y_ext - ny_ext;
        s1_strad_reg <= (y < py) != (ny < py);
        s2_l_reg     <= PW'(s1_a_reg) * PW'(s1_b_reg);
        s2_r_reg     <= PW'(s1_c_reg) * PW'(s1_d_reg);
        s2_strad_reg <= s1_strad_reg;
        s2_dneg_reg  <= s1_d_reg[DW-1];
    end

    assign stat.busy = s1_valid_reg || s2_valid_reg;
    assign stat.hit  = hit_reg;

endmodule

FILE: src/pipr_walker.sv
// ----------------------------------------------------------------------------
// pipr_walker
// query sequencer: walks every ring edge through the shared edge unit
// ----------------------------------------------------------------------------
module pipr_walker #(
    parameter int MAX_VERTS  = pipr_pkg::MAX_VERTS_DEF,
    parameter int NUM_RINGS  = pipr_pkg::NUM_RINGS_DEF,
    parameter int COORD_BITS = pipr_pkg::COORD_BITS_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  start,
    input  logic signed [COORD_BITS-1:0]                          px,
    input  logic signed [COORD_BITS-1:0]                          py,
    input  logic [pipr_pkg::NUM_COUNT_REGS-1:0][pipr_pkg::CNT_W-1:0] counts,
    input  logic                                                  take,
    input  logic [2*COORD_BITS-1:0]                               rd_data,
    output logic                                                  rd_en,
    output logic [(NUM_RINGS*MAX_VERTS > 1 ? $clog2(NUM_RINGS*MAX_VERTS) : 1)-1:0] rd_addr,
    output pipr_pkg::walk_stat_t                                  stat,
    output logic [pipr_pkg::CROSS_W-1:0]                          crossings
);

    localparam int DEPTH = NUM_RINGS * MAX_VERTS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int RW    = NUM_RINGS > 1 ? $clog2(NUM_RINGS) : 1;

    pipr_pkg::walk_state_t          state_reg;
    pipr_pkg::walk_state_t          state_next;
    pipr_pkg::edge_stat_t           edge_stat;

    logic [RW-1:0]                  ring_reg;
    logic [AW-1:0]                  base_reg;
    logic [pipr_pkg::CNT_W-1:0]     idx_reg;
    logic                           rd_valid_reg;
    logic                           rd_first_reg;
    logic [pipr_pkg::CROSS_W-1:0]   count_reg;
    logic signed [COORD_BITS-1:0]   px_reg;
    logic signed [COORD_BITS-1:0]   py_reg;
    logic signed [COORD_BITS-1:0]   prev_x_reg;
    logic signed [COORD_BITS-1:0]   prev_y_reg;

    logic [pipr_pkg::CNT_W-1:0]     ring_size;
    logic                           size_zero;
    logic                           at_end;
    logic                           last_ring;
    logic                           advance;
    logic signed [COORD_BITS-1:0]   cur_x;
    logic signed [COORD_BITS-1:0]   cur_y;

    // vertex count of the current ring, capped at the ring capacity
    always_comb
    begin
        ring_size = '0;
        for (int k = 0; k < pipr_pkg::NUM_COUNT_REGS; k++)
        begin
            if (32'(ring_reg) == k)
            begin
                if (32'(counts[k]) > MAX_VERTS)
                begin
                    ring_size = pipr_pkg::CNT_W'(MAX_VERTS);
                end
                else
                begin
                    ring_size = counts[k];
                end
            end
        end
    end

    assign size_zero = ring_size == '0;
    assign at_end    = idx_reg == ring_size;
    assign last_ring = ring_reg == RW'(NUM_RINGS - 1);
    assign advance   = size_zero || at_end;
    assign cur_x     = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign cur_y     = rd_data[COORD_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pipr_pkg::WS_IDLE:
            begin
                if (start)
                begin
                    state_next = pipr_pkg::WS_WALK;
                end
            end
            pipr_pkg::WS_WALK:
            begin
                if (advance && last_ring)
                begin
                    state_next = pipr_pkg::WS_DRAIN;
                end
            end
            pipr_pkg::WS_DRAIN:
            begin
                if (!rd_valid_reg && !edge_stat.busy)
                begin
                    state_next = pipr_pkg::WS_RESULT;
                end
            end
            pipr_pkg::WS_RESULT:
            begin
                if (take)
                begin
                    state_next = pipr_pkg::WS_IDLE;
                end
            end
            default:
            begin
                state_next = pipr_pkg::WS_IDLE;
            end
        endcase
    end

    // each ring is read as v0 .. v(n-1) and then v0 again to close it
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = base_reg;
        stat.idle = 1'b0;
        stat.done = 1'b0;
        case (state_reg)
            pipr_pkg::WS_IDLE:
            begin
                stat.idle = 1'b1;
            end
            pipr_pkg::WS_WALK:
            begin
                rd_en   = !size_zero;
                rd_addr = AW'(32'(base_reg) + (at_end ? 32'd0 : 32'(idx_reg)));
            end
            pipr_pkg::WS_DRAIN:
            begin
                rd_en = 1'b0;
            end
            pipr_pkg::WS_RESULT:
            begin
                stat.done = 1'b1;
            end
            default:
            begin
                stat.idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pipr_pkg::WS_IDLE;
            ring_reg     <= '0;
            base_reg     <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
            rd_first_reg <= idx_reg == '0;
            if (edge_stat.hit)
            begin
                count_reg <= count_reg + pipr_pkg::CROSS_W'(1);
            end
            if (start && state_reg == pipr_pkg::WS_IDLE)
            begin
                ring_reg  <= '0;
                base_reg  <= '0;
                idx_reg   <= '0;
                count_reg <= '0;
            end
            else if (state_reg == pipr_pkg::WS_WALK)
            begin
                if (advance)
                begin
                    ring_reg <= ring_reg + RW'(1);
                    base_reg <= AW'(32'(base_reg) + MAX_VERTS);
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + pipr_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == pipr_pkg::WS_IDLE)
        begin
            px_reg <= px;
            py_reg <= py;
        end
        if (rd_valid_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

    pipr_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_valid (rd_valid_reg && !rd_first_reg),
        .x          (prev_x_reg),
        .y          (prev_y_reg),
        .nx         (cur_x),
        .ny         (cur_y),
        .px         (px_reg),
        .py         (py_reg),
        .stat       (edge_stat)
    );

    assign crossings = count_reg;

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (!edge_stat.busy && !rd_valid_reg && !edge_stat.hit))
        else $error("result offered while edges still in flight");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == pipr_pkg::WS_IDLE)
        else $error("query started while a walk is running");

    a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pipr_pkg::WS_RESULT |=> $stable(count_reg))
        else $error("crossing count moved after the walk finished");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> 32'(rd_addr) < DEPTH)
        else $error("vertex read beyond the store");

endmodule

FILE: src/point_in_polygon_rings_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_rings_unit
// even-odd point in polygon test over several closed vertex rings
//
// in_ch carries items: op load writes one vertex of ring ring_sel at
// vertex_index, op query gives a point. out_ch returns one item per query:
// the number of ring edges crossed by a leftward ray and its parity.
// The apb port holds the vertex count of each ring at byte address 4*i.
// A load gives no result. A query reads every vertex of every non-empty
// ring through the single read port of the vertex ram, one per cycle,
// plus one more per ring to close it, then drains the edge pipeline and
// hands the result over. No item is accepted from the start of a query
// until its result is handed over, while it walks, drains or waits for
// the output slot. The finished result sits in an output register, so
// loads and the next query go on while the receiver stalls; a later
// query waits at its end until that slot frees.
// Reset clears the counts and all control state; the vertex ram is not
// cleared and a vertex must be loaded before a query reads it.
// ----------------------------------------------------------------------------
module point_in_polygon_rings_unit #(
    parameter int MAX_VERTS  = pipr_pkg::MAX_VERTS_DEF,
    parameter int NUM_RINGS  = pipr_pkg::NUM_RINGS_DEF,
    parameter int COORD_BITS = pipr_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pipr_pkg::PADDR_W-1:0]  paddr,
    input  logic [pipr_pkg::PDATA_W-1:0]  pwdata,
    output logic [pipr_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    pipr_in_if.sink                       in_ch,
    pipr_out_if.source                    out_ch
);

    localparam int DEPTH = NUM_RINGS * MAX_VERTS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic [pipr_pkg::NUM_COUNT_REGS-1:0][pipr_pkg::CNT_W-1:0] count_reg;

    pipr_pkg::walk_stat_t           walk_stat;
    logic                           in_accept;
    logic                           start;
    logic                           load_we;
    logic [AW-1:0]                  load_addr;
    logic [2*COORD_BITS-1:0]        load_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [2*COORD_BITS-1:0]        rd_data;
    logic                           take;
    logic [pipr_pkg::CROSS_W-1:0]   walk_crossings;
    logic                           cfg_we;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_inside_reg;
    logic [pipr_pkg::CROSS_W-1:0]   out_cross_reg;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        for (int k = 0; k < pipr_pkg::NUM_COUNT_REGS; k++)
        begin
            if (32'(paddr[pipr_pkg::PADDR_W-1:2]) == k)
            begin
                prdata = pipr_pkg::PDATA_W'(count_reg[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            for (int k = 0; k < pipr_pkg::NUM_COUNT_REGS; k++)
            begin
                if (32'(paddr[pipr_pkg::PADDR_W-1:2]) == k)
                begin
                    count_reg[k] <= pwdata[pipr_pkg::CNT_W-1:0];
                end
            end
        end
    end

    assign in_ch.ready = walk_stat.idle;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign start       = in_accept && in_ch.op == pipr_pkg::OP_QUERY;

    // loads outside the ring or its capacity are dropped
    assign load_we   = in_accept && in_ch.op == pipr_pkg::OP_LOAD
                       && 32'(in_ch.ring_sel) < NUM_RINGS
                       && 32'(in_ch.vertex_index) < MAX_VERTS;
    assign load_addr = AW'(32'(in_ch.ring_sel) * MAX_VERTS + 32'(in_ch.vertex_index));
    assign load_data = {in_ch.coord_east[COORD_BITS-1:0], in_ch.coord_north[COORD_BITS-1:0]};

    pipr_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (load_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pipr_walker #(
        .MAX_VERTS  (MAX_VERTS),
        .NUM_RINGS  (NUM_RINGS),
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .px        (in_ch.coord_east[COORD_BITS-1:0]),
        .py        (in_ch.coord_north[COORD_BITS-1:0]),
        .counts    (count_reg),
        .take      (take),
        .rd_data   (rd_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .stat      (walk_stat),
        .crossings (walk_crossings)
    );

    // output slot
    assign take = walk_stat.done && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_inside_reg <= walk_crossings[0];
            out_cross_reg  <= walk_crossings;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.inside_res = out_inside_reg;
    assign out_ch.crossings  = out_cross_reg;

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the point in polygon ring unit
//
// Loads vertex rings over the item channel, sets the ring counts over the
// apb port while the unit is quiet and sends point queries. Each accepted
// query is scored by a local even-odd ray casting predictor with exact
// wide products, and every result item is compared against the oldest
// expected one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LOAD_SETTLE  = 8;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 60;
    localparam int BOX          = 1000;
    localparam int RING_STRIDE  = 4;

    localparam int RING_HOLE  = 0;
    localparam int RING_SPAN  = 1;
    localparam int RING_DOT   = 2;
    localparam int RING_PAIR  = 3;
    localparam int RING_OUTER = 4;
    localparam int SEL_TOP    = 7;

    localparam int SHAPE_BOX     = 0;
    localparam int SHAPE_STEPPED = 1;
    localparam int SHAPE_WIDE    = 2;

    localparam int NRINGS = pipr_pkg::NUM_RINGS_DEF;
    localparam int NVERTS = pipr_pkg::MAX_VERTS_DEF;

    localparam logic signed [pipr_pkg::COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [pipr_pkg::COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic                                   op;
        logic [pipr_pkg::RING_SEL_W-1:0]        ring_sel;
        logic [pipr_pkg::VIDX_W-1:0]            vertex_index;
        logic signed [pipr_pkg::COORD_W-1:0]    east;
        logic signed [pipr_pkg::COORD_W-1:0]    north;
    } ring_item_t;

    typedef struct {
        logic                                   inside_flag;
        logic [pipr_pkg::CROSS_W-1:0]           crossings;
    } ray_result_t;

    typedef struct {
        logic signed [pipr_pkg::COORD_W-1:0]    east;
        logic signed [pipr_pkg::COORD_W-1:0]    north;
    } ring_pt_t;

    logic                               clk;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [pipr_pkg::PADDR_W-1:0]       paddr;
    logic [pipr_pkg::PDATA_W-1:0]       pwdata;
    logic [pipr_pkg::PDATA_W-1:0]       prdata;
    logic                               pready;

    pipr_in_if  in_ch ();
    pipr_out_if out_ch ();

    point_in_polygon_rings_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // predictor state
    logic signed [pipr_pkg::COORD_W-1:0]    vertex_east_mem  [NRINGS*NVERTS];
    logic signed [pipr_pkg::COORD_W-1:0]    vertex_north_mem [NRINGS*NVERTS];
    logic [pipr_pkg::CNT_W-1:0]             ring_len [NRINGS];

    ring_item_t     pending_items [$];
    ray_result_t    pending_results [$];
    ring_pt_t       phase_pts [$];

    ring_item_t     drv_item;
    ray_result_t    want;
    int             ring_shape [NRINGS];
    int             queued_total;
    int             accepted_total;
    int             counted_items;
    int             fail_cnt;
    int             in_gap;
    int             out_stall;
    int             calm_in;
    int             calm_out;
    int             cycle_cnt;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // even-odd crossing count of a leftward ray from (px, py)
    function automatic logic [pipr_pkg::CROSS_W-1:0] ray_crossings(
        logic signed [pipr_pkg::COORD_W-1:0] px,
        logic signed [pipr_pkg::COORD_W-1:0] py);
        int unsigned                            total;
        int                                     r;
        int                                     j;
        int                                     k;
        int                                     n;
        int                                     base;
        logic signed [pipr_pkg::COORD_W-1:0]    x0;
        logic signed [pipr_pkg::COORD_W-1:0]    y0;
        logic signed [pipr_pkg::COORD_W-1:0]    x1;
        logic signed [pipr_pkg::COORD_W-1:0]    y1;
        logic signed [127:0]                    a;
        logic signed [127:0]                    b;
        logic signed [127:0]                    c;
        logic signed [127:0]                    d;
        logic signed [127:0]                    lhs;
        logic signed [127:0]                    rhs;
        total = 0;
        for (r = 0; r < NRINGS; r++)
        begin
            n = (ring_len[r] > NVERTS) ? NVERTS : int'(ring_len[r]);
            base = r * NVERTS;
            for (j = 0; j < n; j++)
            begin
                k = (j + 1 == n) ? 0 : j + 1;
                x0 = vertex_east_mem[base + j];
                y0 = vertex_north_mem[base + j];
                x1 = vertex_east_mem[base + k];
                y1 = vertex_north_mem[base + k];
                if ((y0 >= py && y1 < py) || (y0 < py && y1 >= py))
                begin
                    a = py - y1;
                    b = x0 - x1;
                    c = px - x1;
                    d = y0 - y1;
                    lhs = a * b;
                    rhs = c * d;
                    // dividing by a negative span flips the comparison
                    if ((d < 0) ? (rhs < lhs) : (lhs < rhs))
                        total++;
                end
            end
        end
        return total[pipr_pkg::CROSS_W-1:0];
    endfunction

    function automatic logic signed [pipr_pkg::COORD_W-1:0] near_coord(int centre,
                                                                       int spread);
        return centre + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic logic signed [pipr_pkg::COORD_W-1:0] shape_coord(int style,
                                                                        int centre);
        case (style)
            SHAPE_BOX:     return near_coord(centre, BOX);
            SHAPE_STEPPED: return centre + 100 * int'($urandom_range(0, 10)) - 500;
            default:       return $urandom;
        endcase
    endfunction

    task automatic push_load(int sel, int idx, logic signed [pipr_pkg::COORD_W-1:0] e,
                             logic signed [pipr_pkg::COORD_W-1:0] n);
        ring_item_t it;
        it.op           = pipr_pkg::OP_LOAD;
        it.ring_sel     = pipr_pkg::RING_SEL_W'(sel);
        it.vertex_index = pipr_pkg::VIDX_W'(idx);
        it.east         = e;
        it.north        = n;
        pending_items.push_back(it);
        queued_total++;
        if (sel < NRINGS)
        begin
            counted_items++;
            phase_pts.push_back('{e, n});
        end
    endtask

    task automatic push_query(logic signed [pipr_pkg::COORD_W-1:0] e,
                              logic signed [pipr_pkg::COORD_W-1:0] n);
        ring_item_t it;
        it.op           = pipr_pkg::OP_QUERY;
        it.ring_sel     = pipr_pkg::RING_SEL_W'($urandom);
        it.vertex_index = pipr_pkg::VIDX_W'($urandom);
        it.east         = e;
        it.north        = n;
        pending_items.push_back(it);
        queued_total++;
        counted_items++;
    endtask

    task automatic load_ring_shape(int ring, int n, int style, int ce, int cn);
        int idx;
        for (idx = 0; idx < n; idx++)
            push_load(ring, idx, shape_coord(style, ce), shape_coord(style, cn));
    endtask

    task automatic push_random_query(int ce, int cn);
        int                                     pick;
        ring_pt_t                               pt;
        logic signed [pipr_pkg::COORD_W-1:0]    qe;
        logic signed [pipr_pkg::COORD_W-1:0]    qn;
        pick = $urandom_range(0, 99);
        if (phase_pts.size() > 0)
            pt = phase_pts[$urandom_range(0, phase_pts.size() - 1)];
        else
        begin
            pt.east  = near_coord(ce, BOX);
            pt.north = near_coord(cn, BOX);
        end
        qe = near_coord(ce, BOX + 200);
        qn = near_coord(cn, BOX + 200);
        if (pick < 25)
            qn = pt.north;
        else if (pick < 35)
        begin
            qe = pt.east;
            qn = pt.north;
        end
        else if (pick < 50)
        begin
            qe = $urandom;
            qn = $urandom;
        end
        else if (pick < 60)
        begin
            qe = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
            qn = ($urandom_range(0, 2) == 0) ? COORD_MIN : COORD_MAX;
        end
        push_query(qe, qn);
    endtask

    task automatic wait_quiet();
        while (accepted_total != queued_total || pending_results.size() != 0)
            @(posedge clk);
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic write_ring_count(int ring, logic [pipr_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pipr_pkg::PADDR_W'(ring * RING_STRIDE);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_len[ring] = value[pipr_pkg::CNT_W-1:0];
    endtask

    task automatic random_phase();
        int ce;
        int cn;
        int r;
        int k;
        int pick;
        int vidx;
        int want_len [NRINGS];
        ce = $signed($urandom) >>> 1;
        cn = $signed($urandom) >>> 1;
        wait_quiet();
        phase_pts.delete();
        for (r = 0; r < NRINGS; r++)
        begin
            pick = $urandom_range(0, 3);
            want_len[r] = (pick == 0) ? 0 :
                          (pick == 1) ? $urandom_range(1, 3) : $urandom_range(3, 16);
            ring_shape[r] = $urandom_range(SHAPE_BOX, SHAPE_WIDE);
            write_ring_count(r, want_len[r]);
        end
        for (r = 0; r < NRINGS; r++)
            load_ring_shape(r, want_len[r], ring_shape[r], ce, cn);
        for (k = 0; k < 24; k++)
        begin
            pick = $urandom_range(0, 99);
            r = $urandom_range(0, NRINGS - 1);
            vidx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NVERTS - 1)
                                               : $urandom_range(0, 15);
            if (pick < 55)
                push_random_query(ce, cn);
            else if (pick < 85)
                push_load(r, vidx,
                          shape_coord(ring_shape[r], ce), shape_coord(ring_shape[r], cn));
            else
                push_load($urandom_range(NRINGS, SEL_TOP), $urandom_range(0, 1023),
                          $urandom, $urandom);
        end
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap      <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                accepted_total++;
                if (drv_item.op == pipr_pkg::OP_QUERY)
                begin
                    want.crossings   = ray_crossings(drv_item.east, drv_item.north);
                    want.inside_flag = want.crossings[0];
                    pending_results.push_back(want);
                end
                else if (drv_item.ring_sel < NRINGS)
                begin
                    vertex_east_mem[drv_item.ring_sel * NVERTS + drv_item.vertex_index]
                        = drv_item.east;
                    vertex_north_mem[drv_item.ring_sel * NVERTS + drv_item.vertex_index]
                        = drv_item.north;
                end
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    in_gap      <= in_gap - 1;
                end
                else if (pending_items.size() > 0)
                begin
                    drv_item = pending_items.pop_front();
                    in_ch.op           <= drv_item.op;
                    in_ch.ring_sel     <= drv_item.ring_sel;
                    in_ch.vertex_index <= drv_item.vertex_index;
                    in_ch.coord_east   <= drv_item.east;
                    in_ch.coord_north  <= drv_item.north;
                    in_ch.valid        <= 1'b1;
                    in_gap             <= next_gap(calm_in);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item: inside_res %0d crossings %0d",
                           out_ch.inside_res, out_ch.crossings);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.inside_res !== want.inside_flag)
                    begin
                        $error("inside_res: expected %0d, actual %0d",
                               want.inside_flag, out_ch.inside_res);
                        fail_cnt++;
                    end
                    if (out_ch.crossings !== want.crossings)
                    begin
                        $error("crossings: expected %0d, actual %0d",
                               want.crossings, out_ch.crossings);
                        fail_cnt++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                out_stall    <= out_stall - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    out_stall <= next_gap(calm_out);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int r;
        int start_items;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.op           = pipr_pkg::OP_LOAD;
        in_ch.ring_sel     = '0;
        in_ch.vertex_index = '0;
        in_ch.coord_east   = '0;
        in_ch.coord_north  = '0;
        out_ch.ready       = 1'b0;
        queued_total       = 0;
        accepted_total     = 0;
        counted_items      = 0;
        fail_cnt           = 0;
        calm_in            = 0;
        calm_out           = 0;
        cycle_cnt          = 0;
        for (r = 0; r < NRINGS; r++)
            ring_len[r] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty rings, ignored selects, then the directed shapes
        push_load(NRINGS, 3, 32'sh1234_5678, -32'sd1);
        push_load(SEL_TOP, 1023, COORD_MIN, COORD_MAX);
        push_query(COORD_MIN, COORD_MIN);
        push_query(COORD_MAX, COORD_MAX);
        push_load(RING_OUTER, 0, -1000, -1000);
        push_load(RING_OUTER, 1, 1000, -1000);
        push_load(RING_OUTER, 2, 1000, 1000);
        push_load(RING_OUTER, 3, -1000, 1000);
        push_load(RING_HOLE, 0, -200, -200);
        push_load(RING_HOLE, 1, 200, -200);
        push_load(RING_HOLE, 2, 0, 300);
        push_load(RING_SPAN, 0, COORD_MIN, COORD_MIN);
        push_load(RING_SPAN, 1, COORD_MAX, COORD_MIN);
        push_load(RING_SPAN, 2, 0, COORD_MAX);
        push_load(RING_DOT, 0, 5, 5);
        push_load(RING_PAIR, 0, -500, -800);
        push_load(RING_PAIR, 1, 500, 800);
        wait_quiet();
        write_ring_count(RING_HOLE, 3);
        write_ring_count(RING_SPAN, 3);
        write_ring_count(RING_DOT, 1);
        write_ring_count(RING_PAIR, 2);
        write_ring_count(RING_OUTER, 4);
        push_query(0, 0);
        push_query(500, 0);
        push_query(1500, 0);
        // on a vertex row and on an edge column
        push_query(0, -1000);
        push_query(-1000, 0);
        push_query(COORD_MAX, 0);
        push_query(COORD_MIN, 0);
        push_query(0, COORD_MIN);
        push_query(COORD_MAX, COORD_MAX);

        start_items = counted_items;
        while (counted_items < start_items + RANDOM_ITEMS)
            random_phase();

        wait_quiet();
        for (r = 0; r < NRINGS; r++)
            write_ring_count(r, 0);
        push_query(0, 0);
        push_query(COORD_MIN, COORD_MAX);

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
src/pipr_pkg.sv
src/pipr_in_if.sv
src/pipr_out_if.sv
src/pipr_ram.sv
src/pipr_edge_unit.sv
src/pipr_walker.sv
src/point_in_polygon_rings_unit.sv
verif/testbench.sv
